FILE: rtl/core/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int MAX_SYMBOLS      = 16;
    localparam int TABLE_SLOTS      = 16;
    localparam int SYMBOL_W         = 8;
    localparam int DIGIT_W          = 4;
    localparam int RADIX_W          = 5;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int DIV_STEP_BITS    = 8;

    localparam logic [SYMBOL_W-1:0] SIGN_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] SIGN_PLUS  = 8'h2B;

    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } div_stat_t;

endpackage

FILE: rtl/core/sirt_ram.sv
// ----------------------------------------------------------------------------
// sirt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sirt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sirt_table.sv
// ----------------------------------------------------------------------------
// sirt_table
// Symbol table check and digit to symbol lookup.
// ----------------------------------------------------------------------------
module sirt_table
    import sirt_pkg::*;
(
    input  logic [RADIX_W-1:0]    symbol_count,
    input  logic [CFG_DATA_W-1:0] symbols_low,
    input  logic [CFG_DATA_W-1:0] symbols_high,
    input  logic [DIGIT_W-1:0]    digit,
    output logic                  valid,
    output logic [SYMBOL_W-1:0]   symbol
);

    logic [SYMBOL_W-1:0] sym [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] in_use;
    logic [TABLE_SLOTS-1:0] bad_sym;
    logic [TABLE_SLOTS-1:0] dup_sym;
    logic count_ok;

    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS / 2; i++)
        begin
            sym[i]                   = symbols_low[i*SYMBOL_W +: SYMBOL_W];
            sym[i + TABLE_SLOTS / 2] = symbols_high[i*SYMBOL_W +: SYMBOL_W];
        end
    end

    // Every pair of slots in use is compared independently.
    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            in_use[i]  = (RADIX_W'(i) < symbol_count);
            bad_sym[i] = in_use[i] && (sym[i] == '0 || sym[i] == SIGN_MINUS
                                       || sym[i] == SIGN_PLUS);
            dup_sym[i] = 1'b0;
            for (int j = i + 1; j < TABLE_SLOTS; j++)
            begin
                if (in_use[j] && sym[j] == sym[i])
                begin
                    dup_sym[i] = 1'b1;
                end
            end
        end
    end

    assign count_ok = (symbol_count >= RADIX_W'(2))
                   && (symbol_count <= RADIX_W'(MAX_SYMBOLS));
    assign valid    = count_ok && !(|bad_sym) && !(|dup_sym);
    assign symbol   = sym[digit];

endmodule

FILE: rtl/core/sirt_div.sv
// ----------------------------------------------------------------------------
// sirt_div
// Iterative divider by a small radix, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module sirt_div
    import sirt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [((NUMBER_WIDTH+DIV_STEP_BITS-1)/DIV_STEP_BITS)*DIV_STEP_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]  radix,
    output logic [((NUMBER_WIDTH+DIV_STEP_BITS-1)/DIV_STEP_BITS)*DIV_STEP_BITS-1:0] quotient,
    output div_stat_t           stat
);

    localparam int CHUNKS = (NUMBER_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int MAG_W  = CHUNKS * DIV_STEP_BITS;
    localparam int CNT_W  = $clog2(CHUNKS + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0]   work_step;
    logic [DIGIT_W-1:0] rem_step;

    // Restoring division over one chunk: the dividend shifts out at the top
    // while the quotient bits shift in at the bottom of the same word.
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [MAG_W-1:0]   w;
        r = {1'b0, rem_reg};
        w = work_reg;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            r = {r[DIGIT_W-1:0], w[MAG_W-1]};
            w = {w[MAG_W-2:0], 1'b0};
            if (r >= radix)
            begin
                r    = r - radix;
                w[0] = 1'b1;
            end
        end
        work_step = w;
        rem_step  = r[DIGIT_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = work_step;
            rem_next  = rem_step;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CHUNKS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quotient  = work_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

FILE: rtl/core/signed_int_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Renders a signed number as text in a radix set by a programmable table.
// ----------------------------------------------------------------------------
// Each accepted number is sent out as one symbol byte per beat, most
// significant digit first, with a leading '-' for negatives and tlast on the
// final digit; an invalid symbol table sends nothing. One number is handled
// at a time and tready stays low until its last beat has been taken. The
// digits come from one shared divider that retires eight bits a cycle, one
// division per digit, and are then read back from a small stack RAM through
// the READ, LOAD and SEND states, each beat waiting in SEND until the sink
// is ready. A number is accepted in IDLE and the table is checked in CHECK.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text
    import sirt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // number
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // symbol
    output logic [SYMBOL_W-1:0]           m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int CHUNKS = (NUMBER_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int MAG_W  = CHUNKS * DIV_STEP_BITS;
    localparam int AW     = $clog2(NUMBER_WIDTH);
    localparam int NDIG_W = $clog2(NUMBER_WIDTH + 1);

    logic [RADIX_W-1:0]     symbol_count_reg;
    logic [CFG_DATA_W-1:0]  symbols_low_reg;
    logic [CFG_DATA_W-1:0]  symbols_high_reg;

    state_t                 state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]    out_symbol_reg, out_symbol_next;
    logic                   out_last_reg, out_last_next;

    logic [NUMBER_WIDTH-1:0] raw;
    logic                   div_start;
    logic [MAG_W-1:0]       quotient;
    div_stat_t              div_stat;
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [DIGIT_W-1:0]     ram_rdata;
    logic [NDIG_W-1:0]      ndig_dec;
    logic                   tab_valid;
    logic [SYMBOL_W-1:0]    tab_symbol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_wdata[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wdata;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    sirt_table u_table (
        .symbol_count (symbol_count_reg),
        .symbols_low  (symbols_low_reg),
        .symbols_high (symbols_high_reg),
        .digit        (ram_rdata),
        .valid        (tab_valid),
        .symbol       (tab_symbol)
    );

    sirt_div #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (MAG_W'(mag_reg)),
        .radix    (symbol_count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Digits arrive least significant first and are read back as a stack.
    sirt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (NUMBER_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ndig_reg[AW-1:0]),
        .wdata (div_stat.rem),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign raw       = s_axis_tdata[NUMBER_WIDTH-1:0];
    assign ndig_dec  = ndig_reg - NDIG_W'(1);
    assign ram_raddr = ndig_dec[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        ndig_next       = ndig_reg;
        out_valid_next  = out_valid_reg;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        s_axis_tready   = 1'b0;
        div_start       = 1'b0;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    neg_next   = raw[NUMBER_WIDTH-1];
                    mag_next   = raw[NUMBER_WIDTH-1] ? (~raw + 1'b1) : raw;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ndig_next  = '0;
                state_next = tab_valid ? ST_DIV_START : ST_IDLE;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    ram_we    = 1'b1;
                    ndig_next = ndig_reg + NDIG_W'(1);
                    mag_next  = quotient[NUMBER_WIDTH-1:0];
                    if (quotient != '0)
                    begin
                        state_next = ST_DIV_START;
                    end
                    else if (neg_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_symbol_next = SIGN_MINUS;
                        out_last_next   = 1'b0;
                        state_next      = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SIGN:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                ndig_next  = ndig_dec;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_symbol_next = tab_symbol;
                out_last_next   = (ndig_reg == '0);
                state_next      = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ndig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_symbol_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_out_only_when_sending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_SIGN || state_reg == ST_SEND))
        else $error("output beat presented outside a sending state");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while an output beat is pending");

    a_digit_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ndig_reg < NDIG_W'(NUMBER_WIDTH)))
        else $error("digit stack overflow");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the wait state");
`endif

endmodule
